// ----- src/hdc_pkg.sv -----
// ----------------------------------------------------------------------------
// hdc_pkg: header decompressor shared definitions
// Sizes, opcode fields, fixed dictionary and controller/datapath interface.
// ----------------------------------------------------------------------------
package hdc_pkg;

	// history size and longest back reference
	localparam int HIST_DEPTH = 2048;
	localparam int MAX_RUN    = 64;

	localparam int ADDR_W     = $clog2(HIST_DEPTH);
	localparam int POS_W      = $clog2(HIST_DEPTH + 1);
	localparam int N_W        = 8;   // copy length up to 127 + 7 + 2
	localparam int DIST_W     = 13;  // copy distance up to 7 + 4095 + 136
	localparam int CMP_W      = (POS_W + 1 > DIST_W) ? POS_W + 1 : DIST_W;
	localparam int CNT_W      = $clog2(MAX_RUN + 1);
	localparam int EXT_LEN_W  = 7;
	localparam int EXT_DIST_W = 12;
	localparam int LIT_W      = 7;
	localparam int IDX_W      = 6;
	localparam int ADDR_BYTES = 32;  // source plus destination address bytes
	localparam int DICT_LEN   = 48;
	localparam int ADDR_BITS  = 256;

	// opcode fields
	localparam logic [3:0] OP_ZERO_RUN  = 4'h8;
	localparam logic [2:0] OP_EXTEND    = 3'b101;
	localparam logic [1:0] OP_COPY      = 2'b11;
	localparam int         RUN_BIAS     = 2;
	localparam int         EXT_LEN_MAX  = 127;
	localparam int         EXT_DIST_MAX = 4095;

	// decoded class of the held compressed byte
	typedef enum logic [2:0] {
		CLS_LIT,    // byte inside an open literal run
		CLS_OPEN,   // opens a literal run
		CLS_ZERO,   // zero run
		CLS_EXT,    // length/distance extension
		CLS_COPY,   // back reference
		CLS_NOP     // reserved codes, ignored
	} cls_t;

	// source of the byte written and emitted
	typedef enum logic [1:0] {
		SRC_ZERO,
		SRC_LIT,
		SRC_RAM
	} src_t;

	// controller to datapath
	typedef struct packed {
		logic cap;        // accept a compressed byte
		logic start;      // accept a start item
		logic load_step;  // write one dictionary byte
		logic decode;     // apply the held byte to the state
		logic rd;         // issue a history read
		logic emit;       // write and emit one payload byte
		logic err_emit;   // emit the error result
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		cls_t cls;
		logic bad;
		logic cnt_last;
		logic from_ram;
		logic load_last;
		logic out_free;
	} stat_t;

	// fixed tail of the dictionary
	function automatic logic [7:0] dict_byte(input logic [3:0] idx);
		logic [7:0] b;
		unique case (idx)
			4'd0:  b = 8'h16;
			4'd1:  b = 8'hfe;
			4'd2:  b = 8'hfd;
			4'd3:  b = 8'h17;
			4'd4:  b = 8'hfe;
			4'd5:  b = 8'hfd;
			4'd7:  b = 8'h01;
			4'd13: b = 8'h01;
			default: b = 8'h00;
		endcase
		return b;
	endfunction

endpackage

// ----- src/hdc_ram.sv -----
// ----------------------------------------------------------------------------
// hdc_ram: generic single-port-write RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module hdc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2048
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ----- src/hdc_ctrl.sv -----
// ----------------------------------------------------------------------------
// hdc_ctrl: decompressor controller
// Sequences dictionary load, decode, history reads and result emission.
// ----------------------------------------------------------------------------
module hdc_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	input  logic           mode,
	output logic           in_ready,
	input  hdc_pkg::stat_t stat,
	output hdc_pkg::cmd_t  cmd
);
	import hdc_pkg::*;

	typedef enum logic [5:0] {
		ST_IDLE   = 6'b000001,
		ST_LOAD   = 6'b000010,
		ST_DECODE = 6'b000100,
		ST_RD     = 6'b001000,
		ST_WR     = 6'b010000,
		ST_ERR    = 6'b100000
	} state_t;

	state_t state_q, state_d;
	logic   accept;

	assign in_ready = (state_q == ST_IDLE);
	assign accept   = in_valid && in_ready;

	// next state and commands
	always_comb begin
		state_d      = state_q;
		cmd          = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (mode) begin
						cmd.cap = 1'b1;
						state_d = ST_DECODE;
					end else begin
						cmd.start = 1'b1;
						state_d   = ST_LOAD;
					end
				end
			end
			ST_LOAD: begin
				cmd.load_step = 1'b1;
				if (stat.load_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_DECODE: begin
				cmd.decode = 1'b1;
				case (stat.cls) inside
					CLS_LIT, CLS_ZERO: state_d = stat.bad ? ST_ERR : ST_WR;
					CLS_COPY:          state_d = stat.bad ? ST_ERR : ST_RD;
					default:           state_d = ST_IDLE;
				endcase
			end
			ST_RD: begin
				cmd.rd  = 1'b1;
				state_d = ST_WR;
			end
			ST_WR: begin
				if (stat.out_free) begin
					cmd.emit = 1'b1;
					if (stat.cnt_last) begin
						state_d = ST_IDLE;
					end else if (stat.from_ram) begin
						state_d = ST_RD;
					end
				end
			end
			ST_ERR: begin
				if (stat.out_free) begin
					cmd.err_emit = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// ----- src/hdc_datapath.sv -----
// ----------------------------------------------------------------------------
// hdc_datapath: decompressor datapath
// Holds history, write position, extensions, run counters and output register.
// ----------------------------------------------------------------------------
module hdc_datapath (
	input  logic           clk,
	input  logic           arst_n,
	input  hdc_pkg::cmd_t  cmd,
	output hdc_pkg::stat_t stat,
	output logic           hist_we,
	input  logic [7:0]     comp_byte,
	input  logic [63:0]    src_addr_hi,
	input  logic [63:0]    src_addr_lo,
	input  logic [63:0]    dst_addr_hi,
	input  logic [63:0]    dst_addr_lo,
	output logic           out_valid,
	input  logic           out_ready,
	output logic [7:0]     out_byte,
	output logic           last,
	output logic           error
);
	import hdc_pkg::*;

	// state and held item
	logic [7:0]            byte_q;
	logic [ADDR_BITS-1:0]  addr_q;
	logic [POS_W-1:0]      wp_q;
	logic [EXT_LEN_W-1:0]  ext_len_q;
	logic [EXT_DIST_W-1:0] ext_dist_q;
	logic [LIT_W-1:0]      lit_q;
	logic [CNT_W-1:0]      cnt_q;
	logic [ADDR_W-1:0]     rd_ptr_q;
	src_t                  src_q;
	logic [IDX_W-1:0]      ld_idx_q;
	logic                  out_valid_q;
	logic [7:0]            out_byte_q;
	logic                  last_q;
	logic                  error_q;

	// decode terms
	logic [N_W-1:0]        zero_n;
	logic [N_W-1:0]        copy_n;
	logic [DIST_W-1:0]     copy_dist;
	logic [CMP_W-1:0]      wp_ext;
	logic                  zero_ovf;
	logic                  copy_ovf;
	logic                  hist_full;
	logic                  copy_long;
	logic                  copy_far;
	cls_t                  cls;
	logic                  bad;
	logic [EXT_LEN_W:0]    len_sum;
	logic [EXT_DIST_W:0]   dist_sum;
	logic [CMP_W-1:0]      src_pos;

	// memory ports
	logic [ADDR_W-1:0]     waddr;
	logic [7:0]            wdata;
	logic [7:0]            rdata;
	logic [7:0]            ld_byte;
	logic [7:0]            wr_byte;
	logic                  out_free;

	assign zero_n    = N_W'(byte_q[3:0]) + N_W'(RUN_BIAS);
	assign copy_n    = N_W'(ext_len_q) + N_W'(byte_q[5:3]) + N_W'(RUN_BIAS);
	assign copy_dist = DIST_W'(byte_q[2:0]) + DIST_W'(ext_dist_q) + DIST_W'(copy_n);
	assign wp_ext    = CMP_W'(wp_q);
	assign zero_ovf  = (wp_ext + CMP_W'(zero_n)) > CMP_W'(HIST_DEPTH);
	assign copy_ovf  = (wp_ext + CMP_W'(copy_n)) > CMP_W'(HIST_DEPTH);
	assign hist_full = wp_ext >= CMP_W'(HIST_DEPTH);
	assign copy_long = copy_n > N_W'(MAX_RUN);
	assign copy_far  = CMP_W'(copy_dist) > wp_ext;
	assign src_pos   = wp_ext - CMP_W'(copy_dist);
	assign len_sum   = (EXT_LEN_W + 1)'(ext_len_q) + (byte_q[4] ? (EXT_LEN_W + 1)'(8) : '0);
	assign dist_sum  = (EXT_DIST_W + 1)'(ext_dist_q) + (EXT_DIST_W + 1)'({byte_q[3:0], 3'b000});

	// classify the held byte
	always_comb begin
		if (lit_q != '0) begin
			cls = CLS_LIT;
		end else if (!byte_q[7]) begin
			cls = CLS_OPEN;
		end else if (byte_q[7:4] == OP_ZERO_RUN) begin
			cls = CLS_ZERO;
		end else if (byte_q[7:5] == OP_EXTEND) begin
			cls = CLS_EXT;
		end else if (byte_q[7:6] == OP_COPY) begin
			cls = CLS_COPY;
		end else begin
			cls = CLS_NOP;
		end
	end

	// error conditions per class
	always_comb begin
		case (cls)
			CLS_LIT:  bad = hist_full;
			CLS_ZERO: bad = zero_ovf;
			CLS_COPY: bad = copy_long || copy_far || copy_ovf;
			default:  bad = 1'b0;
		endcase
	end

	// byte written to history and emitted
	always_comb begin
		case (src_q)
			SRC_LIT: wr_byte = byte_q;
			SRC_RAM: wr_byte = rdata;
			default: wr_byte = 8'h00;
		endcase
	end

	assign ld_byte  = (ld_idx_q < IDX_W'(ADDR_BYTES)) ? addr_q[ADDR_BITS-1 -: 8]
	                                                  : dict_byte(ld_idx_q[3:0]);
	assign hist_we  = cmd.load_step || cmd.emit;
	assign waddr    = cmd.load_step ? ADDR_W'(ld_idx_q) : wp_q[ADDR_W-1:0];
	assign wdata    = cmd.load_step ? ld_byte : wr_byte;
	assign out_free = !out_valid_q || out_ready;

	hdc_ram #(
		.WIDTH (8),
		.DEPTH (HIST_DEPTH)
	) u_hist (
		.clk   (clk),
		.we    (hist_we),
		.waddr (waddr),
		.wdata (wdata),
		.re    (cmd.rd),
		.raddr (rd_ptr_q),
		.rdata (rdata)
	);

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q       <= '0;
			ext_len_q  <= '0;
			ext_dist_q <= '0;
			lit_q      <= '0;
			cnt_q      <= '0;
			src_q      <= SRC_ZERO;
			ld_idx_q   <= '0;
		end else begin
			if (cmd.start) begin
				ext_len_q  <= '0;
				ext_dist_q <= '0;
				lit_q      <= '0;
				ld_idx_q   <= '0;
			end
			if (cmd.load_step) begin
				ld_idx_q <= ld_idx_q + IDX_W'(1);
				if (stat.load_last) begin
					wp_q <= POS_W'(DICT_LEN);
				end
			end
			if (cmd.decode) begin
				case (cls)
					CLS_LIT: begin
						lit_q <= lit_q - LIT_W'(1);
						cnt_q <= CNT_W'(1);
						src_q <= SRC_LIT;
					end
					CLS_OPEN: lit_q <= byte_q[LIT_W-1:0];
					CLS_ZERO: begin
						cnt_q <= CNT_W'(zero_n);
						src_q <= SRC_ZERO;
					end
					CLS_EXT: begin
						ext_len_q  <= (len_sum > (EXT_LEN_W + 1)'(EXT_LEN_MAX))
							? EXT_LEN_W'(EXT_LEN_MAX) : len_sum[EXT_LEN_W-1:0];
						ext_dist_q <= (dist_sum > (EXT_DIST_W + 1)'(EXT_DIST_MAX))
							? EXT_DIST_W'(EXT_DIST_MAX) : dist_sum[EXT_DIST_W-1:0];
					end
					CLS_COPY: begin
						ext_len_q  <= '0;
						ext_dist_q <= '0;
						cnt_q      <= CNT_W'(copy_n);
						src_q      <= SRC_RAM;
					end
					default: ;
				endcase
			end
			if (cmd.emit) begin
				wp_q  <= wp_q + POS_W'(1);
				cnt_q <= cnt_q - CNT_W'(1);
			end
		end
	end

	// held item and read pointer
	always_ff @(posedge clk) begin
		if (cmd.cap) begin
			byte_q <= comp_byte;
		end
		if (cmd.start) begin
			addr_q <= {src_addr_hi, src_addr_lo, dst_addr_hi, dst_addr_lo};
		end else if (cmd.load_step) begin
			addr_q <= {addr_q[ADDR_BITS-9:0], 8'h00};
		end
		if (cmd.decode) begin
			rd_ptr_q <= src_pos[ADDR_W-1:0];
		end else if (cmd.emit) begin
			rd_ptr_q <= rd_ptr_q + ADDR_W'(1);
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit || cmd.err_emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_byte_q <= wr_byte;
			last_q     <= (cnt_q == CNT_W'(1));
			error_q    <= 1'b0;
		end else if (cmd.err_emit) begin
			out_byte_q <= 8'h00;
			last_q     <= 1'b1;
			error_q    <= 1'b1;
		end
	end

	assign out_valid = out_valid_q;
	assign out_byte  = out_byte_q;
	assign last      = last_q;
	assign error     = error_q;

	assign stat.cls       = cls;
	assign stat.bad       = bad;
	assign stat.cnt_last  = (cnt_q == CNT_W'(1));
	assign stat.from_ram  = (src_q == SRC_RAM);
	assign stat.load_last = (ld_idx_q == IDX_W'(DICT_LEN - 1));
	assign stat.out_free  = out_free;

endmodule

// ----- src/ghc_header_decompressor_unit.sv -----
// ----------------------------------------------------------------------------
// Header decompressor top level
// Start items load the 48-byte dictionary; compressed bytes expand to payload.
// ----------------------------------------------------------------------------
// Start item: accepted, then the 48 dictionary bytes are written; no result.
// Compressed byte: accepted, then decoded; bytes with no result are then done.
// Literals and zero runs give one byte per cycle after decode while the output
// register is free; copies do a history read, then a write and emit, per byte.
// A result waits in an output register; the next item is taken meanwhile.
// Reset clears all control state; history contents stay undefined until written.
module ghc_header_decompressor_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        mode,
	input  logic [7:0]  comp_byte,
	input  logic [63:0] src_addr_hi,
	input  logic [63:0] src_addr_lo,
	input  logic [63:0] dst_addr_hi,
	input  logic [63:0] dst_addr_lo,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  out_byte,
	output logic        last,
	output logic        error
);
	import hdc_pkg::*;

	cmd_t  cmd;
	stat_t stat;
	logic  hist_we;

	hdc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.mode     (mode),
		.in_ready (in_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	hdc_datapath u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.stat        (stat),
		.hist_we     (hist_we),
		.comp_byte   (comp_byte),
		.src_addr_hi (src_addr_hi),
		.src_addr_lo (src_addr_lo),
		.dst_addr_hi (dst_addr_hi),
		.dst_addr_lo (dst_addr_lo),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.out_byte    (out_byte),
		.last        (last),
		.error       (error)
	);

`ifndef SYNTHESIS
	// an error result is a lone zero byte closing its item
	a_err_shape: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && error |-> last && out_byte == 8'h00)
		else $error("error result not a lone zero byte");

	// history is only written while an item is in progress
	a_we_busy: assert property (@(posedge clk) disable iff (!arst_n)
		hist_we |-> !in_ready)
		else $error("history written while idle");

	// an accepted item always keeps the controller busy for the next cycle
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("controller idle right after accept");
`endif

endmodule
